@@ sv/bpa_pkg.sv @@
// Shared definitions for the buddy page allocator: sizes, codes, FSM types
// and the controller/datapath command and status bundles. No dependencies.
`timescale 1ns / 1ps

package bpa_pkg;

  // Pool geometry.
  localparam int MAX_ORDER_LEVEL = 10;
  localparam int MAX_POOL_PAGES  = 4096;
  localparam int AW = $clog2(MAX_POOL_PAGES);     // page address bits
  localparam int LW = AW + 1;                     // link bits, includes null marker
  localparam int OW = $clog2(MAX_ORDER_LEVEL + 2); // order bits, holds MAX+1
  localparam logic [LW-1:0] NIL_LINK = LW'(MAX_POOL_PAGES);

  // Register map.
  localparam logic REG_POOL_PAGES = 1'b0;

  // Command codes.
  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOBLOCK = 2'd1;
  localparam logic [1:0] ST_BADCNT  = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_ICLEAR, S_ISTEP, S_ASRCH, S_AUNL, S_SPLIT,
    S_FR, S_FBCHK, S_FBEVAL, S_PUSHA, S_PUSHB, S_DONE
  } state_t;

  typedef enum logic [1:0] {RET_INIT, RET_SPLIT, RET_FR} ret_t;

  typedef struct packed {
    logic       load;
    logic       clr_start;
    logic       clr_step;
    logic       init_setup;
    logic       init_push;
    logic       ord_dec;
    logic       alloc_setup;
    logic       ord_inc;
    logic       alloc_take;
    logic       fb_read;
    logic       unlink;
    logic       merge;
    logic       split_push;
    logic       fr_step;
    logic       fb_push;
    logic       push_a;
    logic       push_b;
    logic       range_alloc;
    logic       range_free;
    logic       set_status;
    logic [1:0] status_code;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       lim_zero;
    logic       alloc_bad;
    logic       free_bad_n;
    logic       free_oob;
    logic       clr_last;
    logic       init_fits;
    logic       ord_zero;
    logic       cur_over;
    logic       head_empty;
    logic       fb_stop;
    logic       fb_match;
    logic       split_more;
    logic       tail;
    logic       fr_done;
    logic       out_busy;
  } dp_stat_t;

  // Block size of an order, in pages.
  function automatic logic [LW-1:0] pow2(input logic [OW-1:0] o);
    return LW'(1) << o;
  endfunction

endpackage

@@ sv/buddy_page_allocator_unit.sv @@
// Buddy page allocator top level: configuration register, controller and datapath.
// A rejected or unknown command goes straight to the result; an allocation steps through the
// order search and then each split, and a free lays out each block and each merge in turn.
// Init first clears the free-head marks of all MAX_POOL_PAGES pages; after the result register
// loads, the controller returns to idle for the next transaction. Reset (synchronous) runs a
// clearing pass.
`timescale 1ns / 1ps

module buddy_page_allocator_unit
  import bpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [11:0] page_index,
  input  logic [12:0] page_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [11:0] block_index,
  output logic [12:0] free_total
);

  logic [12:0] pool_pages;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  assign pready = 1'b1;

  // Pool size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_pages <= 13'd4096;
    end else if (psel && penable && pwrite && paddr[2] == REG_POOL_PAGES) begin
      pool_pages <= pwdata[12:0];
    end
  end

  // Register read.
  assign prdata = (paddr[2] == REG_POOL_PAGES) ? {19'b0, pool_pages} : 32'b0;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bpa_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .pool_pages  (pool_pages),
    .command     (command),
    .page_index  (page_index),
    .page_count  (page_count),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .status      (status),
    .block_index (block_index),
    .free_total  (free_total)
  );

endmodule

@@ sv/bpa_ctrl.sv @@
// Controller state machine of the buddy page allocator.
// Depends on bpa_pkg; drives the datapath through dp_cmd_t.
`timescale 1ns / 1ps

module bpa_ctrl
  import bpa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;
  ret_t   ret, ret_next;

  // State and return-point registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ret   <= RET_INIT;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    ret_next   = ret;
    unique case (state)
      S_CLEAR: begin
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (stat.cmd)
          CMD_INIT:  state_next = stat.lim_zero ? S_DONE : S_ICLEAR;
          CMD_ALLOC: state_next = stat.alloc_bad ? S_DONE : S_ASRCH;
          CMD_FREE:  state_next = (stat.free_bad_n || stat.free_oob) ? S_DONE : S_FR;
          default:   state_next = S_DONE;
        endcase
      end
      S_ICLEAR: begin
        if (stat.clr_last) state_next = S_ISTEP;
      end
      S_ISTEP: begin
        if (stat.init_fits) begin
          state_next = S_PUSHA;
          ret_next   = RET_INIT;
        end else if (stat.ord_zero) begin
          state_next = S_DONE;
        end
      end
      S_ASRCH: begin
        if (stat.cur_over) state_next = S_DONE;
        else if (!stat.head_empty) state_next = S_AUNL;
      end
      S_AUNL: state_next = S_SPLIT;
      S_SPLIT: begin
        if (stat.split_more) begin
          state_next = S_PUSHA;
          ret_next   = RET_SPLIT;
        end else if (stat.tail) begin
          state_next = S_FR;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FR: begin
        state_next = stat.fr_done ? S_DONE : S_FBCHK;
      end
      S_FBCHK: begin
        if (stat.fb_stop) begin
          state_next = S_PUSHA;
          ret_next   = RET_FR;
        end else begin
          state_next = S_FBEVAL;
        end
      end
      S_FBEVAL: begin
        if (stat.fb_match) begin
          state_next = S_FBCHK;
        end else begin
          state_next = S_PUSHA;
          ret_next   = RET_FR;
        end
      end
      S_PUSHA: state_next = S_PUSHB;
      S_PUSHB: begin
        unique case (ret)
          RET_INIT:  state_next = S_ISTEP;
          RET_SPLIT: state_next = S_SPLIT;
          RET_FR:    state_next = S_FR;
          default:   state_next = S_FR;
        endcase
      end
      S_DONE: begin
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_DECODE: begin
        unique case (stat.cmd)
          CMD_INIT: begin
            if (stat.lim_zero) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_BADCNT;
            end else begin
              cmd.clr_start = 1'b1;
            end
          end
          CMD_ALLOC: begin
            if (stat.alloc_bad) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_BADCNT;
            end else begin
              cmd.alloc_setup = 1'b1;
            end
          end
          CMD_FREE: begin
            if (stat.free_bad_n) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_BADCNT;
            end else if (stat.free_oob) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_RANGE;
            end else begin
              cmd.range_free = 1'b1;
            end
          end
          default: cmd.set_status = 1'b0;
        endcase
      end
      S_ICLEAR: begin
        cmd.clr_step   = 1'b1;
        cmd.init_setup = stat.clr_last;
      end
      S_ISTEP: begin
        if (stat.init_fits) cmd.init_push = 1'b1;
        else if (!stat.ord_zero) cmd.ord_dec = 1'b1;
      end
      S_ASRCH: begin
        if (stat.cur_over) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_NOBLOCK;
        end else if (!stat.head_empty) begin
          cmd.alloc_take = 1'b1;
        end else begin
          cmd.ord_inc = 1'b1;
        end
      end
      S_AUNL: cmd.unlink = 1'b1;
      S_SPLIT: begin
        if (stat.split_more) cmd.split_push = 1'b1;
        else if (stat.tail) cmd.range_alloc = 1'b1;
      end
      S_FR: cmd.fr_step = !stat.fr_done;
      S_FBCHK: begin
        if (stat.fb_stop) cmd.fb_push = 1'b1;
        else cmd.fb_read = 1'b1;
      end
      S_FBEVAL: begin
        if (stat.fb_match) begin
          cmd.unlink = 1'b1;
          cmd.merge  = 1'b1;
        end else begin
          cmd.fb_push = 1'b1;
        end
      end
      S_PUSHA: cmd.push_a = 1'b1;
      S_PUSHB: cmd.push_b = 1'b1;
      S_DONE:  cmd.out_load = !stat.out_busy;
      default: cmd = '0;
    endcase
  end

`ifndef SYNTHESIS
  // The second push state always follows the first, back to back.
  a_push_pair: assert property (@(posedge clk) disable iff (rst)
    state == S_PUSHA |=> state == S_PUSHB)
    else $error("push sequence broken");

  // Only the idle state takes a new transaction.
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == S_IDLE && in_valid)
    else $error("transaction taken outside idle");

  // Loading the result always returns the controller to idle.
  a_done_exit: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> state == S_IDLE)
    else $error("result load did not return to idle");
`endif

endmodule

@@ sv/bpa_datapath.sv @@
// Datapath of the buddy page allocator: free-list heads, link and page-info
// memories, work registers and the result register. Depends on bpa_pkg.
`timescale 1ns / 1ps

module bpa_datapath
  import bpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [12:0] pool_pages,
  input  logic [1:0]  command,
  input  logic [11:0] page_index,
  input  logic [12:0] page_count,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [1:0]  status,
  output logic [11:0] block_index,
  output logic [12:0] free_total
);

  // Page memories: links and {free-head mark, order}.
  logic [LW-1:0] next_mem [MAX_POOL_PAGES];
  logic [LW-1:0] prev_mem [MAX_POOL_PAGES];
  logic [OW:0]   info_mem [MAX_POOL_PAGES];
  logic [LW-1:0] next_q, prev_q;
  logic [OW:0]   info_q;

  logic [LW-1:0] list_head [MAX_ORDER_LEVEL+1];
  logic [12:0]   free_sum;

  // Captured transaction and work registers.
  logic [1:0]    in_cmd;
  logic [AW-1:0] in_idx;
  logic [12:0]   in_n;
  logic [AW-1:0] clr_cnt;
  logic [OW-1:0] w_ord, want, p_ord;
  logic [AW-1:0] w_idx, p_pg, rd_pg, blk;
  logic [LW-1:0] r_idx, r_n, h_q;
  logic [1:0]    stat_q;

  logic [LW-1:0] lim, head_sel, bud, free_end_chk;
  logic [LW:0]   free_end;
  logic [OW-1:0] want_c, k_c;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  // Pool limit and range checks.
  assign lim      = (pool_pages > LW'(MAX_POOL_PAGES)) ? NIL_LINK : pool_pages;
  assign free_end = (LW+1)'(in_idx) + (LW+1)'(in_n);
  assign free_end_chk = lim;
  assign head_sel = (w_ord <= OW'(MAX_ORDER_LEVEL)) ? list_head[w_ord] : NIL_LINK;
  assign bud      = LW'(w_idx) ^ pow2(w_ord);

  // Order that a requested count rounds up to.
  always_comb begin
    want_c = OW'(MAX_ORDER_LEVEL);
    for (int j = MAX_ORDER_LEVEL; j >= 0; j--) begin
      if (pow2(OW'(j)) >= in_n) want_c = OW'(j);
    end
  end

  // Largest aligned block that starts the remaining range.
  always_comb begin
    k_c = '0;
    for (int j = 0; j <= MAX_ORDER_LEVEL; j++) begin
      if ((r_idx & (pow2(OW'(j)) - LW'(1))) == '0 && pow2(OW'(j)) <= r_n) k_c = OW'(j);
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.cmd        = in_cmd;
    stat.lim_zero   = (lim == '0);
    stat.alloc_bad  = (in_n == '0) || (in_n > pow2(OW'(MAX_ORDER_LEVEL)));
    stat.free_bad_n = (in_n == '0);
    stat.free_oob   = free_end > (LW+1)'(free_end_chk);
    stat.clr_last   = (clr_cnt == '1);
    stat.init_fits  = (r_n >= pow2(w_ord));
    stat.ord_zero   = (w_ord == '0);
    stat.cur_over   = (w_ord > OW'(MAX_ORDER_LEVEL));
    stat.head_empty = head_sel[LW-1];
    stat.fb_stop    = (w_ord >= OW'(MAX_ORDER_LEVEL)) || (bud >= lim);
    stat.fb_match   = info_q[OW] && (info_q[OW-1:0] == w_ord);
    stat.split_more = (w_ord > want);
    stat.tail       = (LW'(in_n) != pow2(want));
    stat.fr_done    = (r_n == '0);
    stat.out_busy   = out_valid && out_stall;
  end

  assign rd_en   = cmd.alloc_take || cmd.fb_read;
  assign rd_addr = cmd.alloc_take ? head_sel[AW-1:0] : bud[AW-1:0];

  // Registered memory reads.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      next_q <= next_mem[rd_addr];
      prev_q <= prev_mem[rd_addr];
      info_q <= info_mem[rd_addr];
      rd_pg  <= rd_addr;
    end
  end

  // Memory writes: clearing pass, push and unlink.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) info_mem[clr_cnt] <= '0;
    if (cmd.push_a) begin
      next_mem[p_pg] <= list_head[p_ord];
      prev_mem[p_pg] <= NIL_LINK;
      info_mem[p_pg] <= {1'b1, p_ord};
    end
    if (cmd.push_b && !h_q[LW-1]) prev_mem[h_q[AW-1:0]] <= LW'(p_pg);
    if (cmd.unlink) begin
      if (!prev_q[LW-1]) next_mem[prev_q[AW-1:0]] <= next_q;
      if (!next_q[LW-1]) prev_mem[next_q[AW-1:0]] <= prev_q;
      info_mem[rd_pg] <= {1'b0, w_ord};
    end
  end

  // List heads, free total and clear counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= MAX_ORDER_LEVEL; i++) list_head[i] <= NIL_LINK;
      free_sum <= '0;
      clr_cnt  <= '0;
    end else begin
      if (cmd.clr_start) begin
        for (int i = 0; i <= MAX_ORDER_LEVEL; i++) list_head[i] <= NIL_LINK;
        free_sum <= '0;
        clr_cnt  <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (cmd.push_a) begin
        list_head[p_ord] <= LW'(p_pg);
        free_sum <= free_sum + pow2(p_ord);
      end else if (cmd.unlink) begin
        if (prev_q[LW-1]) list_head[w_ord] <= next_q;
        free_sum <= free_sum - pow2(w_ord);
      end
    end
  end

  // Work registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_cmd <= command;
      in_idx <= page_index;
      in_n   <= page_count;
      stat_q <= ST_OK;
      blk    <= '0;
    end
    if (cmd.set_status) stat_q <= cmd.status_code;
    if (cmd.push_a) h_q <= list_head[p_ord];
    if (cmd.init_setup) begin
      r_idx <= '0;
      r_n   <= lim;
      w_ord <= OW'(MAX_ORDER_LEVEL);
    end
    if (cmd.init_push) begin
      p_ord <= w_ord;
      p_pg  <= r_idx[AW-1:0];
      r_idx <= r_idx + pow2(w_ord);
      r_n   <= r_n - pow2(w_ord);
    end
    if (cmd.ord_dec) w_ord <= w_ord - OW'(1);
    if (cmd.alloc_setup) begin
      w_ord <= want_c;
      want  <= want_c;
    end
    if (cmd.ord_inc) w_ord <= w_ord + OW'(1);
    if (cmd.alloc_take) begin
      w_idx <= head_sel[AW-1:0];
      blk   <= head_sel[AW-1:0];
    end
    if (cmd.merge) begin
      w_idx <= w_idx & ~AW'(pow2(w_ord));
      w_ord <= w_ord + OW'(1);
    end
    if (cmd.split_push) begin
      w_ord <= w_ord - OW'(1);
      p_ord <= w_ord - OW'(1);
      p_pg  <= w_idx + AW'(pow2(w_ord - OW'(1)));
    end
    if (cmd.range_alloc) begin
      r_idx <= LW'(blk) + in_n;
      r_n   <= pow2(want) - in_n;
    end
    if (cmd.range_free) begin
      r_idx <= LW'(in_idx);
      r_n   <= in_n;
    end
    if (cmd.fr_step) begin
      w_idx <= r_idx[AW-1:0];
      w_ord <= k_c;
      r_idx <= r_idx + pow2(k_c);
      r_n   <= r_n - pow2(k_c);
    end
    if (cmd.fb_push) begin
      p_ord <= w_ord;
      p_pg  <= w_idx;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= stat_q;
      block_index <= blk;
      free_total  <= free_sum;
    end
  end

`ifndef SYNTHESIS
  // An unlink never shares the memory write ports with a push or a clearing step.
  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.unlink |-> !cmd.push_a && !cmd.push_b && !cmd.clr_step)
    else $error("memory write port conflict");

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("pending result overwritten");

  // Allocation only takes a non-empty list head.
  a_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc_take |-> !head_sel[LW-1])
    else $error("took an empty list");

  // The second push cycle follows the first.
  a_push_order: assert property (@(posedge clk) disable iff (rst)
    cmd.push_b |-> $past(cmd.push_a))
    else $error("push second half without first");
`endif

endmodule
